// File: hw/rtl/pihc_pkg.sv
// Shared widths, register indexes, command types and column step tables of the hit checker.
package pihc_pkg;

  localparam int ColW   = 10;
  localparam int RowW   = 9;
  localparam int CntW   = 16;
  localparam int OccW   = 6;
  localparam int PixW   = 20;
  localparam int MissW  = 36;
  localparam int ExtraW = 35;
  localparam int StepW  = 6;
  localparam int RecipW = 17;
  localparam int CfgIdxW = 2;

  // Stream word widths, padded to whole bytes
  localparam int InW  = 40;
  localparam int OutW = 136;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIGGER   = 2'd0,
    CFG_OCCUPANCY = 2'd1,
    CFG_ROW       = 2'd2
  } cfg_index_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic quot;
    logic check;
    logic accumulate;
  } pihc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
    logic out_busy;
  } pihc_status_t;

  // Column step between injected pixels for a given occupancy.
  // Zero behaves as one; a whole row (and anything above) gives step one.
  function automatic logic [StepW-1:0] step_of(input logic [OccW-1:0] occ);
    logic [StepW-1:0] st;
    if (occ <= 6'd1)       st = 6'd32;
    else if (occ == 6'd2)  st = 6'd16;
    else if (occ == 6'd3)  st = 6'd10;
    else if (occ == 6'd4)  st = 6'd8;
    else if (occ == 6'd5)  st = 6'd6;
    else if (occ == 6'd6)  st = 6'd5;
    else if (occ <= 6'd8)  st = 6'd4;
    else if (occ <= 6'd10) st = 6'd3;
    else if (occ <= 6'd16) st = 6'd2;
    else                   st = 6'd1;
    return st;
  endfunction

  // Rounded-up reciprocal 2^16 / step, exact quotient for any 10-bit column
  function automatic logic [RecipW-1:0] recip_of(input logic [StepW-1:0] st);
    logic [RecipW-1:0] r;
    unique case (st)
      6'd32:   r = 17'd2048;
      6'd16:   r = 17'd4096;
      6'd10:   r = 17'd6554;
      6'd8:    r = 17'd8192;
      6'd6:    r = 17'd10923;
      6'd5:    r = 17'd13108;
      6'd4:    r = 17'd16384;
      6'd3:    r = 17'd21846;
      6'd2:    r = 17'd32768;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/pixel_injection_hit_checker_top.sv
// Top level of the pixel injection hit checker: controller, datapath and checks.
//
// Input stream (s_t*): one word per pixel, with column, row and hit count in
// s_tdata and the last pixel of a chip marked by s_tlast. Each pixel is
// classified as dead, inefficient or noisy against the injection pattern
// set by the configuration registers, and the totals are accumulated with
// saturation.
// Output stream (m_t*): one word per chip, issued after its last pixel,
// carrying the five totals; the totals then restart from zero.
// Configuration (cfg_*): trigger count, occupancy and injected row; the user is to
// write them while the block is idle, and the block itself does not enforce this.
// Timing: an item passes four steps (capture, quotient multiply, remainder
// check, accumulate); the remainder test by reciprocal multiplication sets
// the walk. A chip result is registered by the accumulate step of its last pixel.
// One item is in flight at a time, so the input takes no new word until the
// accumulate step of the word before it is done.
// Stalls: the result register holds a waiting chip result while pixels keep
// flowing; a following chip end waits in the accumulate step until the
// receiver takes the earlier result.
// Reset clears the totals, the result valid and restores register defaults.
module pixel_injection_hit_checker_top
  import pihc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CntW-1:0]    cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  // column [9:0], pixel_row [18:10], hit_count [34:19], zero fill [39:35]
  input  logic [InW-1:0]     s_tdata,
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // dead_pixels [19:0], inefficient_pixels [39:20], noisy_pixels [59:40],
  // missing_hits [95:60], extra_hits [130:96], zero fill [135:131]
  output logic [OutW-1:0]    m_tdata
);

  pihc_cmd_t    cmd;
  pihc_status_t stat;

  pihc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pihc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTH
  // Only one step of the sequence is commanded at a time
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.quot, cmd.check, cmd.accumulate}))
    else $error("more than one datapath command active");

  // A taken word closes the input until its accumulate step is done
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // A new result appears only from the accumulate step of a chip end
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.accumulate && stat.last))
    else $error("result raised without a chip end");

  // The accumulate step never overwrites a result still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.accumulate && stat.last |-> !(m_tvalid && !m_tready))
    else $error("waiting result overwritten");
`endif

endmodule

// File: hw/rtl/pihc_ctrl.sv
// Controller state machine sequencing one pixel word through the datapath.
module pihc_ctrl
  import pihc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  pihc_status_t stat,
  output pihc_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_QUOT  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_ACC   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   acc_go;

  // Hold the accumulate step while a chip result still waits downstream
  assign acc_go = (state == ST_ACC) && !(stat.last && stat.out_busy);

  assign s_tready       = (state == ST_IDLE);
  assign cmd.capture    = (state == ST_IDLE) && s_tvalid;
  assign cmd.quot       = (state == ST_QUOT);
  assign cmd.check      = (state == ST_CHECK);
  assign cmd.accumulate = acc_go;

  // Advance through quotient, check and accumulate
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_QUOT;
      ST_QUOT:  state_next = ST_CHECK;
      ST_CHECK: state_next = ST_ACC;
      ST_ACC:   if (acc_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/pihc_dp.sv
// Datapath: configuration, injection test, saturating totals and the result register.
module pihc_dp
  import pihc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_index,
  input  logic [CntW-1:0]       cfg_data,
  input  logic [InW-1:0]        s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OutW-1:0]       m_tdata,
  input  pihc_cmd_t             cmd,
  output pihc_status_t          stat
);

  // Configuration
  logic [CntW-1:0]  trigger;
  logic [OccW-1:0]  occupancy;
  logic [RowW-1:0]  inj_row;

  // Captured word
  logic [ColW-1:0]  col_r;
  logic [RowW-1:0]  row_r;
  logic [CntW-1:0]  cnt_r;
  logic             last_r;

  logic [ColW-1:0]  quot_r;
  logic             injected_r;

  // Totals
  logic [PixW-1:0]   dead_total;
  logic [PixW-1:0]   ineff_total;
  logic [PixW-1:0]   noisy_total;
  logic [MissW-1:0]  missing_total;
  logic [ExtraW-1:0] extra_total;

  logic [PixW-1:0]   dead_next;
  logic [PixW-1:0]   ineff_next;
  logic [PixW-1:0]   noisy_next;
  logic [MissW-1:0]  missing_next;
  logic [ExtraW-1:0] extra_next;

  // Result fields
  logic [PixW-1:0]   out_dead;
  logic [PixW-1:0]   out_ineff;
  logic [PixW-1:0]   out_noisy;
  logic [MissW-1:0]  out_missing;
  logic [ExtraW-1:0] out_extra;

  logic [StepW-1:0]              step;
  logic [RecipW-1:0]             recip;
  logic [ColW+RecipW-1:0]        quot_prod;
  logic [ColW+StepW-1:0]         back_prod;
  logic                          dead_inc;
  logic                          ineff_inc;
  logic                          noisy_inc;
  logic signed [CntW+1:0]        delta;
  logic signed [MissW:0]         miss_sum;
  logic [ExtraW:0]               extra_sum;

  assign step  = step_of(occupancy);
  assign recip = recip_of(step);

  // Configuration writes; index three is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger   <= CntW'(1);
      occupancy <= OccW'(32);
      inj_row   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TRIGGER:   trigger   <= cfg_data;
        CFG_OCCUPANCY: occupancy <= cfg_data[OccW-1:0];
        CFG_ROW:       inj_row   <= cfg_data[RowW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r  <= s_tdata[ColW-1:0];
      row_r  <= s_tdata[ColW+RowW-1:ColW];
      cnt_r  <= s_tdata[ColW+RowW+CntW-1:ColW+RowW];
      last_r <= s_tlast;
    end
  end

  // Quotient column / step by reciprocal, then test the remainder for zero
  assign quot_prod = (ColW+RecipW)'(col_r) * (ColW+RecipW)'(recip);
  assign back_prod = (ColW+StepW)'(quot_r) * (ColW+StepW)'(step);

  always_ff @(posedge clk) begin
    if (cmd.quot) quot_r <= quot_prod[ColW+16-1:16];
    if (cmd.check) injected_r <= (row_r == inj_row) &&
                                 (back_prod == (ColW+StepW)'(col_r));
  end

  // Classify the pixel and form the saturated next totals
  assign dead_inc  = injected_r && (cnt_r == '0);
  assign ineff_inc = injected_r && (cnt_r != '0) && (cnt_r != trigger);
  assign noisy_inc = !injected_r && (cnt_r != '0);
  assign delta     = injected_r ? ($signed({2'b00, trigger}) - $signed({2'b00, cnt_r}))
                                : '0;
  assign miss_sum  = $signed({missing_total[MissW-1], missing_total}) +
                     (MissW+1)'(delta);
  assign extra_sum = {1'b0, extra_total} + (noisy_inc ? (ExtraW+1)'(cnt_r) : '0);

  always_comb begin
    dead_next  = (dead_inc && dead_total != '1) ? dead_total + 1'b1 : dead_total;
    ineff_next = (ineff_inc && ineff_total != '1) ? ineff_total + 1'b1 : ineff_total;
    noisy_next = (noisy_inc && noisy_total != '1) ? noisy_total + 1'b1 : noisy_total;
    priority if (!miss_sum[MissW] && miss_sum[MissW-1])
      missing_next = {1'b0, {(MissW-1){1'b1}}};
    else if (miss_sum[MissW] && !miss_sum[MissW-1])
      missing_next = {1'b1, {(MissW-1){1'b0}}};
    else
      missing_next = miss_sum[MissW-1:0];
    extra_next = extra_sum[ExtraW] ? '1 : extra_sum[ExtraW-1:0];
  end

  // Update totals; on a chip end move them to the result and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_total    <= '0;
      ineff_total   <= '0;
      noisy_total   <= '0;
      missing_total <= '0;
      extra_total   <= '0;
    end else if (cmd.accumulate) begin
      if (last_r) begin
        dead_total    <= '0;
        ineff_total   <= '0;
        noisy_total   <= '0;
        missing_total <= '0;
        extra_total   <= '0;
      end else begin
        dead_total    <= dead_next;
        ineff_total   <= ineff_next;
        noisy_total   <= noisy_next;
        missing_total <= missing_next;
        extra_total   <= extra_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.accumulate && last_r) begin
      out_dead    <= dead_next;
      out_ineff   <= ineff_next;
      out_noisy   <= noisy_next;
      out_missing <= missing_next;
      out_extra   <= extra_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.accumulate && last_r) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'b0, out_extra, out_missing, out_noisy, out_ineff, out_dead};

  assign stat.last     = last_r;
  assign stat.out_busy = m_tvalid && !m_tready;

endmodule

// File: tb/sv/pihc_chip_tally_checker.sv
// Checker for the hit checker: mirrors the registers, tallies each chip and compares totals words.
module pihc_chip_tally_checker
  import pihc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CntW-1:0]    cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  // column [9:0], pixel_row [18:10], hit_count [34:19], zero fill [39:35]
  input  logic [InW-1:0]     s_tdata,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  // dead_pixels [19:0], inefficient_pixels [39:20], noisy_pixels [59:40],
  // missing_hits [95:60], extra_hits [130:96], zero fill [135:131]
  input  logic [OutW-1:0]    m_tdata,
  output int                 outstanding,
  output int                 fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PixW-1:0]         dead;
    logic [PixW-1:0]         inefficient;
    logic [PixW-1:0]         noisy;
    logic signed [MissW-1:0] missing;
    logic [ExtraW-1:0]       extra;
  } chip_totals_t;

  localparam logic [PixW-1:0] PixMax   = '1;
  localparam longint          MissMax  = 64'sd34359738367;
  localparam longint          MissMin  = -64'sd34359738368;
  localparam longint          ExtraMax = 64'sd34359738367;

  localparam int RowLo = ColW;
  localparam int CntLo = ColW + RowW;

  // Register mirror, running tallies and the totals owed to the receiver
  logic [CntW-1:0] trig_count;
  logic [OccW-1:0] occupancy;
  logic [RowW-1:0] inj_row;
  chip_totals_t    running;
  chip_totals_t    owed_totals[$];

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  // Injection pattern: zero occupancy acts as one, anything from 32 up as the whole row
  function automatic bit pixel_injected(logic [ColW-1:0] col, logic [RowW-1:0] row);
    int per32;
    if (row != inj_row) return 1'b0;
    per32 = (occupancy == '0) ? 1 : int'(occupancy);
    if (per32 >= 32) return 1'b1;
    return (int'(col) % (32 / per32)) == 0;
  endfunction

  function automatic logic [PixW-1:0] bump(logic [PixW-1:0] v);
    return (v == PixMax) ? v : v + 1'b1;
  endfunction

  // Classify one pixel and fold it into the running tallies, saturating
  function automatic void tally_pixel(logic [ColW-1:0] col, logic [RowW-1:0] row,
                                      logic [CntW-1:0] hits);
    longint sum;
    if (pixel_injected(col, row)) begin
      sum = longint'(running.missing);
      if (hits == '0) begin
        sum = sum + longint'(trig_count);
        running.dead = bump(running.dead);
      end else if (hits != trig_count) begin
        sum = sum + longint'(trig_count) - longint'(hits);
        running.inefficient = bump(running.inefficient);
      end
      if (sum > MissMax) sum = MissMax;
      if (sum < MissMin) sum = MissMin;
      running.missing = sum[MissW-1:0];
    end else if (hits != '0) begin
      sum = longint'(running.extra) + longint'(hits);
      if (sum > ExtraMax) sum = ExtraMax;
      running.extra = sum[ExtraW-1:0];
      running.noisy = bump(running.noisy);
    end
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    chip_totals_t want;
    if (rst) begin
      trig_count = 16'd1;
      occupancy  = 6'd32;
      inj_row    = '0;
      running    = '0;
      owed_totals.delete();
    end else begin
      // Compare a taken totals word against the oldest chip owed
      if (m_tvalid && m_tready) begin
        if (owed_totals.size() == 0) begin
          $error("totals word with no chip end outstanding");
          fail_count++;
        end else begin
          want = owed_totals.pop_front();
          check_field("dead_pixels", longint'(want.dead), longint'(m_tdata[19:0]));
          check_field("inefficient_pixels", longint'(want.inefficient),
                      longint'(m_tdata[39:20]));
          check_field("noisy_pixels", longint'(want.noisy), longint'(m_tdata[59:40]));
          check_field("missing_hits", longint'(want.missing),
                      longint'($signed(m_tdata[95:60])));
          check_field("extra_hits", longint'(want.extra), longint'(m_tdata[130:96]));
          check_field("zero_fill", 0, longint'(m_tdata[OutW-1:131]));
        end
      end

      // Tally a taken pixel word; on a chip end, owe the totals and restart
      if (s_tvalid && s_tready) begin
        tally_pixel(s_tdata[ColW-1:0], s_tdata[CntLo-1:RowLo], s_tdata[CntLo+CntW-1:CntLo]);
        if (s_tlast) begin
          owed_totals.push_back(running);
          running = '0;
        end
      end

      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER:   trig_count = cfg_data;
          CFG_OCCUPANCY: occupancy  = cfg_data[OccW-1:0];
          CFG_ROW:       inj_row    = cfg_data[RowW-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= owed_totals.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top: clock, reset, pixel stimulus, receiver stalls and the verdict.
module tb_top
  import pihc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    READY_OPEN,
    READY_LIGHT,
    READY_BURSTY,
    READY_HEAVY
  } ready_pattern_t;

  localparam int     DrainCycles  = 8;
  localparam int     RandomPhases = 13;
  localparam int     PhaseItems   = 110;
  localparam longint RunLimitNs   = 4_000_000;

  logic               clk;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_TRIGGER;
  logic [CntW-1:0]    cfg_data  = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [InW-1:0]     s_tdata   = '0;
  logic               s_tlast   = 1'b0;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [OutW-1:0]    m_tdata;
  int                 outstanding;
  int                 fail_count;

  // Register values as last written, used to aim the stimulus
  logic [CntW-1:0] cur_trig = 16'd1;
  logic [OccW-1:0] cur_occ  = 6'd32;
  logic [RowW-1:0] cur_row  = '0;

  int burst_left = 0;
  bit gapless    = 1'b0;

  pixel_injection_hit_checker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  pihc_chip_tally_checker i_tally (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: switch stall pattern now and then, hold ready low for the chosen stall
  ready_pattern_t ready_pattern = READY_OPEN;
  int             pattern_left  = 0;
  int             stall_left    = 0;

  always @(posedge clk) begin
    if (pattern_left == 0) begin
      ready_pattern = ready_pattern_t'($urandom_range(0, 3));
      pattern_left  = $urandom_range(50, 400);
    end else begin
      pattern_left--;
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      case (ready_pattern)
        READY_OPEN:   stall_left = 0;
        READY_LIGHT:  stall_left = $urandom_range(0, 2);
        READY_BURSTY: stall_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
        default:      stall_left = $urandom_range(5, 30);
      endcase
    end
  end

  // Offer one pixel word and hold it until taken; open a new burst after a gap
  task automatic push_pixel(logic [ColW-1:0] col, logic [RowW-1:0] row,
                            logic [CntW-1:0] hits, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= InW'({hits, row, col});
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending, wait for every owed totals word, then let the pipeline drain
  task automatic settle();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_config(logic [CntW-1:0] trig, logic [OccW-1:0] occ,
                             logic [RowW-1:0] row);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRIGGER;
    cfg_data  <= trig;
    @(posedge clk);
    cfg_index <= CFG_OCCUPANCY;
    cfg_data  <= CntW'(occ);
    @(posedge clk);
    cfg_index <= CFG_ROW;
    cfg_data  <= CntW'(row);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_trig  = trig;
    cur_occ   = occ;
    cur_row   = row;
  endtask

  // Random pixel aimed at the injected row and pattern about half the time
  task automatic send_random_pixel(bit last);
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [CntW-1:0] hits;
    int              occ_eff;
    int              step;
    occ_eff = (cur_occ == '0) ? 1 : ((cur_occ > 6'd32) ? 32 : int'(cur_occ));
    step    = 32 / occ_eff;
    row     = ($urandom_range(0, 9) < 6) ? cur_row : RowW'($urandom);
    col     = $urandom_range(0, 1) ? ColW'(step * $urandom_range(0, 1023 / step))
                                   : ColW'($urandom);
    case ($urandom_range(0, 9))
      0:          hits = '0;
      1, 2, 3, 4: hits = cur_trig;
      5:          hits = cur_trig - CntW'($urandom_range(1, 3));
      6:          hits = '1;
      default:    hits = CntW'($urandom);
    endcase
    // Quiet most non-injected pixels, as a real chip would be
    if (row != cur_row && $urandom_range(0, 2) != 0) hits = '0;
    push_pixel(col, row, hits, last);
  endtask

  initial begin
    int sent;
    int target;
    int chip_len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, whole row injected on row 0
    push_pixel(10'd0,    9'd0,   16'd0,     1'b0);
    push_pixel(10'd1023, 9'd0,   16'd1,     1'b0);
    push_pixel(10'd5,    9'd0,   16'hFFFF,  1'b0);
    push_pixel(10'd7,    9'd0,   16'd2,     1'b0);
    push_pixel(10'd0,    9'd511, 16'hFFFF,  1'b0);
    push_pixel(10'd1023, 9'd3,   16'd0,     1'b0);
    push_pixel(10'd512,  9'd0,   16'd0,     1'b1);
    // Chip of one quiet pixel gives all-zero totals
    push_pixel(10'd9,    9'd9,   16'd0,     1'b1);
    settle();

    // Zero trigger count and zero occupancy on the top row
    load_config(16'd0, 6'd0, 9'd511);
    push_pixel(10'd0,    9'd511, 16'd0,     1'b0);
    push_pixel(10'd992,  9'd511, 16'd5,     1'b0);
    push_pixel(10'd31,   9'd511, 16'd7,     1'b0);
    push_pixel(10'd64,   9'd510, 16'd0,     1'b1);
    settle();

    // Largest trigger count, occupancy beyond a whole row
    load_config(16'hFFFF, 6'd63, 9'd300);
    push_pixel(10'd1023, 9'd300, 16'd0,     1'b0);
    push_pixel(10'd1,    9'd300, 16'hFFFF,  1'b0);
    push_pixel(10'd2,    9'd300, 16'hFFFE,  1'b1);
    settle();

    // Uneven column steps
    load_config(16'd20, 6'd3, 9'd5);
    push_pixel(10'd1020, 9'd5,   16'd20,    1'b0);
    push_pixel(10'd1019, 9'd5,   16'd20,    1'b0);
    push_pixel(10'd0,    9'd5,   16'd21,    1'b1);
    settle();
    load_config(16'd100, 6'd6, 9'd7);
    push_pixel(10'd5,    9'd7,   16'd0,     1'b0);
    push_pixel(10'd6,    9'd7,   16'd100,   1'b1);
    settle();
    load_config(16'd2, 6'd17, 9'd0);
    push_pixel(10'd1,    9'd0,   16'd3,     1'b1);

    // Random chips, a fresh setting per phase
    sent = 0;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      settle();
      case (phase)
        0:       load_config(16'hFFFF, 6'd32, 9'd511);
        1:       load_config(16'd0, 6'd1, 9'd0);
        2:       load_config(16'd1, 6'd33, RowW'($urandom));
        3:       load_config(CntW'($urandom), 6'd2, 9'd511);
        default: load_config($urandom_range(0, 1) ? CntW'($urandom_range(0, 8))
                                                  : CntW'($urandom),
                             OccW'($urandom_range(0, 63)), RowW'($urandom));
      endcase
      gapless = ($urandom_range(0, 3) == 0);
      target  = sent + PhaseItems;
      while (sent < target) begin
        chip_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 24);
        for (int k = 0; k < chip_len; k++) begin
          send_random_pixel(k == chip_len - 1);
          sent++;
        end
        // Now and then hold off until the receiver has every totals word
        if ($urandom_range(0, 15) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop should the block hang
  initial begin
    #(RunLimitNs);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pihc_pkg.sv
hw/rtl/pihc_ctrl.sv
hw/rtl/pihc_dp.sv
hw/rtl/pixel_injection_hit_checker_top.sv
tb/sv/pihc_chip_tally_checker.sv
tb/sv/tb_top.sv
